### rtl/core/slvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slvr_pkg;

    // Result kinds
    localparam logic [2:0] KIND_LINE   = 3'd0;
    localparam logic [2:0] KIND_VERTEX = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_COLOR  = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;
    localparam logic [2:0] KIND_BAD    = 3'd5;
    localparam logic [2:0] KIND_TRUNC  = 3'd6;

    // Record types
    localparam logic [7:0] TYPE_UNDOC  = 8'hF7;
    localparam logic [7:0] TYPE_OFFSET = 8'hFB;
    localparam logic [7:0] TYPE_END    = 8'hFC;
    localparam logic [7:0] TYPE_FILL   = 8'hFD;
    localparam logic [7:0] TYPE_COMMON = 8'hFE;
    localparam logic [7:0] TYPE_COLOR  = 8'hFF;

    localparam logic [7:0] COLOR_RESET = 8'd7;
    localparam logic [7:0] VCOUNT_MAX  = 8'hFF;
    localparam int         REC_BYTES   = 8;

    // Register map
    localparam logic REG_BIG_ENDIAN = 1'b0;

    typedef logic [7:0] rec_byte_t;
    typedef rec_byte_t [REC_BYTES-1:0] rec_buf_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       final_byte;
    } slvr_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic [7:0]         color_index;
        logic [7:0]         vertex_count;
    } slvr_result_t;

    function automatic logic [3:0] rec_length(input logic [7:0] t);
        logic [3:0] len;
        len = 4'd2;
        if (!t[7])                  len = 4'd8;
        else if (t == TYPE_OFFSET)  len = 4'd5;
        else if (t == TYPE_FILL)    len = 4'd6;
        else if (t == TYPE_COMMON)  len = 4'd3;
        return len;
    endfunction

    function automatic logic [15:0] rec_word(input logic [7:0] a, input logic [7:0] b,
                                             input logic big);
        return big ? {a, b} : {b, a};
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

`default_nettype wire

### rtl/core/slvr_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module slvr_in_reg
    import slvr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire slvr_item_t s_item,
    input  wire logic       advance,
    output logic            item_vld,
    output slvr_item_t      item
);

    logic       vld_reg;
    logic       vld_next;
    slvr_item_t item_reg;

    // Take a new transaction when empty or when the held one moves on
    assign s_ready  = !vld_reg || advance;
    assign vld_next = s_ready ? s_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

`default_nettype wire

### rtl/core/slvr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module slvr_parser
    import slvr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       big_endian,
    input  wire logic       fire,
    input  wire slvr_item_t item,
    output logic            res_vld,
    output slvr_result_t    res
);

    rec_buf_t    rb_reg,    rb_next;
    logic [2:0]  idx_reg,   idx_next;
    logic [15:0] cx_reg,    cx_next;
    logic [15:0] cy_reg,    cy_next;
    logic [7:0]  color_reg, color_next;
    logic [7:0]  vert_reg,  vert_next;
    logic        done_reg,  done_next;

    always_comb begin
        logic [3:0]  n;
        logic [7:0]  t;
        logic [7:0]  lo;
        logic [15:0] w2;
        logic [15:0] w4;
        logic [15:0] w6;

        rb_next    = rb_reg;
        idx_next   = idx_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        vert_next  = vert_reg;
        done_next  = done_reg;
        res_vld    = 1'b0;
        res        = '0;
        n  = '0;
        t  = '0;
        lo = '0;
        w2 = '0;
        w4 = '0;
        w6 = '0;

        if (fire) begin
            if (item.first_byte) begin
                idx_next   = '0;
                cx_next    = '0;
                cy_next    = '0;
                color_next = COLOR_RESET;
                vert_next  = '0;
                done_next  = 1'b0;
            end
            res.color_index = color_next;

            if (!done_next) begin
                rb_next[idx_next] = item.byte_value;
                n  = {1'b0, idx_next} + 4'd1;
                t  = big_endian ? rb_next[0] : rb_next[1];
                lo = big_endian ? rb_next[1] : rb_next[0];
                w2 = rec_word(rb_next[2], rb_next[3], big_endian);
                w4 = rec_word(rb_next[4], rb_next[5], big_endian);
                w6 = rec_word(rb_next[6], rb_next[7], big_endian);

                if (n >= 4'd2 && n >= rec_length(t)) begin
                    idx_next = '0;
                    if (!t[7]) begin
                        // full vector: header word is the start x
                        cx_next     = {t, lo};
                        cy_next     = w2;
                        res_vld     = 1'b1;
                        res.kind    = KIND_LINE;
                        res.from_x  = {t, lo};
                        res.from_y  = w2;
                        res.to_x    = w4;
                        res.to_y    = w6;
                    end else begin
                        unique case (t)
                            TYPE_UNDOC: begin
                                res_vld = 1'b0;
                            end
                            TYPE_OFFSET: begin
                                // both ends offset from the old cursor
                                res.to_x   = cx_next + sext8(rb_next[3]);
                                res.to_y   = cy_next + sext8(rb_next[4]);
                                cx_next    = cx_next + sext8(lo);
                                cy_next    = cy_next + sext8(rb_next[2]);
                                res_vld    = 1'b1;
                                res.kind   = KIND_LINE;
                                res.from_x = cx_next;
                                res.from_y = cy_next;
                            end
                            TYPE_END: begin
                                done_next = 1'b1;
                                res_vld   = 1'b1;
                                res.kind  = KIND_END;
                            end
                            TYPE_FILL: begin
                                if (!w4[15]) begin
                                    if (vert_next != VCOUNT_MAX) begin
                                        vert_next = vert_next + 8'd1;
                                    end
                                    res_vld    = 1'b1;
                                    res.kind   = KIND_VERTEX;
                                    res.from_x = w2;
                                    res.from_y = w4;
                                end else if (vert_next != 8'd0) begin
                                    res_vld          = 1'b1;
                                    res.kind         = KIND_CLOSE;
                                    res.vertex_count = vert_next;
                                    vert_next        = '0;
                                end
                            end
                            TYPE_COMMON: begin
                                res_vld    = 1'b1;
                                res.kind   = KIND_LINE;
                                res.from_x = cx_next;
                                res.from_y = cy_next;
                                cx_next    = cx_next + sext8(lo);
                                cy_next    = cy_next + sext8(rb_next[2]);
                                res.to_x   = cx_next;
                                res.to_y   = cy_next;
                            end
                            TYPE_COLOR: begin
                                if (lo != color_next) begin
                                    color_next      = lo;
                                    res_vld         = 1'b1;
                                    res.kind        = KIND_COLOR;
                                    res.color_index = lo;
                                end
                            end
                            default: begin
                                done_next = 1'b1;
                                res_vld   = 1'b1;
                                res.kind  = KIND_BAD;
                            end
                        endcase
                    end
                end else begin
                    idx_next = n[2:0];
                    if (item.final_byte) begin
                        // drop the partial record
                        idx_next  = '0;
                        done_next = 1'b1;
                        res_vld   = 1'b1;
                        res.kind  = KIND_TRUNC;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= COLOR_RESET;
            vert_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            vert_reg  <= vert_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rb_reg <= rb_next;
    end

endmodule

`default_nettype wire

### rtl/core/slvr_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module slvr_out_reg
    import slvr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire slvr_result_t res,
    output logic              advance,
    input  wire logic         m_ready,
    output logic              m_valid,
    output slvr_result_t      m_res
);

    logic         vld_reg;
    logic         vld_next;
    slvr_result_t res_reg;

    // Slot is free when empty or when the held transaction leaves this cycle
    assign advance  = !vld_reg || m_ready;
    assign vld_next = load ? 1'b1 : (advance ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = vld_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

### rtl/core/slide_vector_record_decoder_core.sv
// A byte in the input register is decoded once the result slot is free; its result,
// if any, then shows on m_valid (one input register, one result register).
// Throughput: one byte per cycle while the result channel keeps up.
// Reset (aresetn low, synchronous): cursor cleared, color 7, polygon count zero,
// end-of-stream flag cleared, big_endian 0, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module slide_vector_record_decoder_core
    import slvr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_byte_value,
    input  wire logic               s_first_byte,
    input  wire logic               s_final_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_kind,
    output logic signed [15:0]      m_from_x,
    output logic signed [15:0]      m_from_y,
    output logic signed [15:0]      m_to_x,
    output logic signed [15:0]      m_to_y,
    output logic [7:0]              m_color_index,
    output logic [7:0]              m_vertex_count
);

    logic         big_endian_reg;
    logic         big_endian_next;
    logic         advance;
    logic         item_vld;
    logic         fire;
    logic         res_vld;
    slvr_item_t   s_item;
    slvr_item_t   item;
    slvr_result_t res;
    slvr_result_t m_res;

    // Configuration
    assign pready = 1'b1;
    always_comb begin
        big_endian_next = big_endian_reg;
        if (psel && penable && pwrite && paddr[2] == REG_BIG_ENDIAN) begin
            big_endian_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            big_endian_reg <= 1'b0;
        end else begin
            big_endian_reg <= big_endian_next;
        end
    end

    assign prdata = (paddr[2] == REG_BIG_ENDIAN) ? {31'd0, big_endian_reg} : 32'd0;

    assign s_item = '{byte_value: s_byte_value, first_byte: s_first_byte,
                      final_byte: s_final_byte};

    slvr_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .item_vld (item_vld),
        .item     (item)
    );

    assign fire = item_vld && advance;

    slvr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .big_endian (big_endian_reg),
        .fire       (fire),
        .item       (item),
        .res_vld    (res_vld),
        .res        (res)
    );

    slvr_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_vld),
        .res     (res),
        .advance (advance),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_res   (m_res)
    );

    assign m_kind         = m_res.kind;
    assign m_from_x       = m_res.from_x;
    assign m_from_y       = m_res.from_y;
    assign m_to_x         = m_res.to_x;
    assign m_to_y         = m_res.to_y;
    assign m_color_index  = m_res.color_index;
    assign m_vertex_count = m_res.vertex_count;

endmodule

`default_nettype wire

### rtl/core/slvr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slvr_checker
    import slvr_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_kind,
    input wire logic [15:0] m_to_x,
    input wire logic [15:0] m_to_y,
    input wire logic [7:0]  m_vertex_count
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    a_count_only_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_CLOSE |-> m_vertex_count == 8'd0)
        else $error("vertex count on a non-close result");

    a_end_only_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_LINE |-> m_to_x == 16'd0 && m_to_y == 16'd0)
        else $error("line end on a non-line result");

endmodule

bind slide_vector_record_decoder_core slvr_checker u_slvr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .pready         (pready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_to_x         (m_to_x),
    .m_to_y         (m_to_y),
    .m_vertex_count (m_vertex_count)
);

`default_nettype wire
